>>> src/ipid_pkg.sv
package ipid_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int LIM_W   = DATA_W - 1;
    // e - 2*e1 + e2 needs two bits beyond the sample width; OPND_W gives it three.
    localparam int OPND_W  = DATA_W + 3;
    localparam int PROD_W  = DATA_W + OPND_W;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int ACC_W   = TERM_W + 3;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_OUT_LIMIT  = 3'd3,
        REG_SEP_LIMIT  = 3'd4,
        REG_SEP_ENABLE = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        REQ_STEP  = 1'b0,
        REQ_CLEAR = 1'b1
    } req_code_t;

endpackage

>>> src/ipid_req_if.sv
interface ipid_req_if import ipid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [DATA_W-1:0] error_in;

    modport source (output valid, output req_type, output error_in, input ready);
    modport sink (input valid, input req_type, input error_in, output ready);
endinterface

>>> src/ipid_drv_if.sv
interface ipid_drv_if import ipid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] drive_out;

    modport source (output valid, output drive_out, input ready);
    modport sink (input valid, input drive_out, output ready);
endinterface

>>> src/ipid_cfg_if.sv
interface ipid_cfg_if import ipid_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/ipid_mulq.sv
module ipid_mulq import ipid_pkg::*;
(
    input  logic signed [DATA_W-1:0] gain,
    input  logic signed [OPND_W-1:0] operand,
    output logic signed [TERM_W-1:0] term
);

    logic signed [PROD_W-1:0] prod;

    // Dropping the low fraction bits of the exact product floors toward minus infinity.
    assign prod = gain * operand;
    assign term = prod[PROD_W-1:FRAC_W];

endmodule

>>> src/incremental_pid_controller_unit.sv
// Channel | Role   | Payload
// --------+--------+------------------------------------------
// cfg     | sink   | index (register number), data
// req     | sink   | req_type (step or clear), error_in Q16.16
// drv     | source | drive_out Q16.16
//
// An item is registered with its error differences in the stage-one registers; when the
// result register is free, the three gain products, the sum with the previous output and
// the clamp land in it, one item per cycle sustained while the result is not stalled.
// The loop through the previous output register sets that rate.
// Reset clears gains, limits, error history and the previous output.
// A stalled result holds the pipeline; req stays ready while a slot is free.
module incremental_pid_controller_unit import ipid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    ipid_cfg_if.sink   cfg,
    ipid_req_if.sink   req,
    ipid_drv_if.source drv
);

    logic signed [DATA_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIM_W-1:0]         out_limit_reg, sep_limit_reg;
    logic                     sep_enable_reg;

    logic [DATA_W-1:0]        e1_reg, e2_reg, last_drive_reg;

    logic                     s1_valid_reg, s1_clear_reg, s1_drop_i_reg;
    logic signed [OPND_W-1:0] s1_e_reg, s1_d1_reg, s1_d2_reg;

    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_drive_reg;

    logic                     in_fire, s1_adv;
    logic signed [OPND_W-1:0] e_x, e1_x, e2_x, d1_next, d2_next;
    logic [DATA_W:0]          mag;
    logic                     drop_i_next;

    logic signed [TERM_W-1:0] term_p, term_i, term_d;
    logic signed [ACC_W-1:0]  acc, lim, neg_lim, smax, smin, clamped;
    logic [DATA_W-1:0]        drive_next;

    assign cfg.ready = 1'b1;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || drv.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign in_fire   = req.valid && req.ready;

    assign e_x  = {{(OPND_W-DATA_W){req.error_in[DATA_W-1]}}, req.error_in};
    assign e1_x = {{(OPND_W-DATA_W){e1_reg[DATA_W-1]}}, e1_reg};
    assign e2_x = {{(OPND_W-DATA_W){e2_reg[DATA_W-1]}}, e2_reg};
    assign d1_next = e_x - e1_x;
    assign d2_next = e_x - (e1_x <<< 1) + e2_x;

    always_comb
    begin
        if (req.error_in[DATA_W-1])
        begin
            mag = (DATA_W+1)'(-e_x);
        end
        else
        begin
            mag = {1'b0, req.error_in};
        end
    end

    assign drop_i_next = sep_enable_reg && (mag > {2'b00, sep_limit_reg});

    ipid_mulq u_mul_p (.gain(gain_p_reg), .operand(s1_d1_reg), .term(term_p));
    ipid_mulq u_mul_i (.gain(gain_i_reg), .operand(s1_e_reg),  .term(term_i));
    ipid_mulq u_mul_d (.gain(gain_d_reg), .operand(s1_d2_reg), .term(term_d));

    always_comb
    begin
        acc = {{(ACC_W-DATA_W){last_drive_reg[DATA_W-1]}}, last_drive_reg}
            + {{(ACC_W-TERM_W){term_p[TERM_W-1]}}, term_p}
            + {{(ACC_W-TERM_W){term_d[TERM_W-1]}}, term_d};
        if (!s1_drop_i_reg)
        begin
            acc = acc + {{(ACC_W-TERM_W){term_i[TERM_W-1]}}, term_i};
        end
        lim     = {{(ACC_W-LIM_W){1'b0}}, out_limit_reg};
        neg_lim = -lim;
        smax    = {{(ACC_W-LIM_W){1'b0}}, {LIM_W{1'b1}}};
        smin    = ~smax;
        if (out_limit_reg != '0)
        begin
            if (acc > lim)
            begin
                clamped = lim;
            end
            else if (acc < neg_lim)
            begin
                clamped = neg_lim;
            end
            else
            begin
                clamped = acc;
            end
        end
        else
        begin
            if (acc > smax)
            begin
                clamped = smax;
            end
            else if (acc < smin)
            begin
                clamped = smin;
            end
            else
            begin
                clamped = acc;
            end
        end
        if (s1_clear_reg)
        begin
            drive_next = '0;
        end
        else
        begin
            drive_next = clamped[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            out_limit_reg  <= '0;
            sep_limit_reg  <= '0;
            sep_enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GAIN_P:     gain_p_reg     <= cfg.data;
                REG_GAIN_I:     gain_i_reg     <= cfg.data;
                REG_GAIN_D:     gain_d_reg     <= cfg.data;
                REG_OUT_LIMIT:  out_limit_reg  <= cfg.data[LIM_W-1:0];
                REG_SEP_LIMIT:  sep_limit_reg  <= cfg.data[LIM_W-1:0];
                REG_SEP_ENABLE: sep_enable_reg <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // The error history moves at acceptance, so the next item sees it at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg       <= '0;
            e2_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (req.req_type == REQ_CLEAR)
                begin
                    e1_reg <= '0;
                    e2_reg <= '0;
                end
                else
                begin
                    e1_reg <= req.error_in;
                    e2_reg <= e1_reg;
                end
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_clear_reg  <= (req.req_type == REQ_CLEAR);
            s1_e_reg      <= e_x;
            s1_d1_reg     <= d1_next;
            s1_d2_reg     <= d2_next;
            s1_drop_i_reg <= drop_i_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_drive_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                last_drive_reg <= drive_next;
                out_valid_reg  <= 1'b1;
            end
            else if (drv.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_drive_reg <= drive_next;
        end
    end

    assign drv.valid     = out_valid_reg;
    assign drv.drive_out = out_drive_reg;

endmodule

>>> src/ipid_checker.sv
module ipid_checker import ipid_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_req_type,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] out_drive
);

    // Input back-pressure only comes from a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("request stalled without a stalled result");

    // A clear reaches the output as zero when the result slot is free as it leaves stage one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_req_type == REQ_CLEAR) ##1 (!out_valid || out_ready)
        |=> (out_valid && out_drive == '0))
        else $error("clear did not produce a zero output");

    // Every result traces back to an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without an accepted item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_drive)))
        else $error("stalled result changed or dropped");

endmodule

bind incremental_pid_controller_unit ipid_checker u_ipid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_req_type (req.req_type),
    .out_valid   (drv.valid),
    .out_ready   (drv.ready),
    .out_drive   (drv.drive_out)
);
